>>> hdl/rbst_pkg.sv
// Package for the ray/box slab test: widths and axis count.
// No dependencies.
package rbst_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned NumAxes   = 3;

endpackage

>>> hdl/rbst_div.sv
// Pipelined saturating slab-distance divider: ((a - o) << FRAC) / d, one quotient bit per stage.
// Depends on rbst_pkg.
module rbst_div #(
  parameter int unsigned CoordBits = rbst_pkg::CoordBits,
  parameter int unsigned SideBits  = 8
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CoordBits-1:0] a_i,
  input  logic signed [CoordBits-1:0] o_i,
  input  logic signed [CoordBits-1:0] d_i,
  input  logic [SideBits-1:0]         side_i,
  output logic signed [CoordBits-1:0] t_o,
  output logic [SideBits-1:0]         side_o
);
  localparam int unsigned FracBits = rbst_pkg::FracBits;
  localparam int unsigned MagBits  = CoordBits + 1;
  localparam int unsigned NumBits  = MagBits + FracBits;
  // Quotient bits beyond CoordBits mean overflow; keep CoordBits+1 bits.
  localparam int unsigned QBits    = CoordBits + 1;

  // Stage state: one row per quotient bit plus the setup row.
  logic [NumBits-1:0]  num_q  [NumBits+1];
  logic [MagBits-1:0]  den_q  [NumBits+1];
  logic [MagBits:0]    rem_q  [NumBits+1];
  logic [QBits-1:0]    quo_q  [NumBits+1];
  logic                ovf_q  [NumBits+1];
  logic                neg_q  [NumBits+1];
  logic [SideBits-1:0] side_q [NumBits+1];

  logic signed [MagBits-1:0] diff;
  logic signed [MagBits-1:0] dext;
  assign diff = MagBits'(a_i) - MagBits'(o_i);
  assign dext = MagBits'(d_i);

  // Take magnitudes and sign at entry.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= {(diff[MagBits-1] ? MagBits'(-diff) : diff), FracBits'(0)};
      den_q[0]  <= dext[MagBits-1] ? MagBits'(-dext) : dext;
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      ovf_q[0]  <= 1'b0;
      neg_q[0]  <= diff[MagBits-1] ^ dext[MagBits-1];
      side_q[0] <= side_i;
    end
  end

  // Restoring division, one bit per stage, MSB first.
  for (genvar s = 0; s < NumBits; s++) begin : g_step
    logic [MagBits:0] sh;
    logic [MagBits:0] sub;
    logic             qb;
    assign sh  = {rem_q[s][MagBits-1:0], num_q[s][NumBits-1-s]};
    assign qb  = sh >= {1'b0, den_q[s]};
    assign sub = qb ? sh - {1'b0, den_q[s]} : sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= num_q[s];
        den_q[s+1]  <= den_q[s];
        rem_q[s+1]  <= sub;
        quo_q[s+1]  <= {quo_q[s][QBits-2:0], qb};
        ovf_q[s+1]  <= ovf_q[s] | quo_q[s][QBits-1];
        neg_q[s+1]  <= neg_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  // Saturate and apply sign.
  logic [QBits-1:0] lim;
  logic [QBits-1:0] qf;
  logic             big;
  assign lim = neg_q[NumBits] ? (QBits'(1) << (CoordBits-1))
                              : ((QBits'(1) << (CoordBits-1)) - QBits'(1));
  assign big = ovf_q[NumBits] | quo_q[NumBits][QBits-1] | (quo_q[NumBits] > lim);
  assign qf  = big ? lim : quo_q[NumBits];
  assign t_o = neg_q[NumBits] ? CoordBits'(-qf) : CoordBits'(qf);
  assign side_o = side_q[NumBits];

endmodule

>>> hdl/rbst_axis.sv
// One axis: zero-direction check, inside test and ordered slab entry/exit distances.
// Depends on rbst_pkg and rbst_div.
module rbst_axis #(
  parameter int unsigned CoordBits = rbst_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CoordBits-1:0] o_i,
  input  logic signed [CoordBits-1:0] d_i,
  input  logic signed [CoordBits-1:0] lo_i,
  input  logic signed [CoordBits-1:0] hi_i,
  output logic signed [CoordBits-1:0] t0_o,
  output logic signed [CoordBits-1:0] t1_o,
  output logic                        par_o,
  output logic                        miss_o,
  output logic                        in_o
);
  // side bits: parallel, parallel miss, strictly inside
  logic [2:0] side_in, side_lo, side_hi;
  logic signed [CoordBits-1:0] ta, tb;
  assign side_in = {d_i == '0, (d_i == '0) & ((o_i < lo_i) | (o_i > hi_i)),
                    (o_i > lo_i) & (o_i < hi_i)};

  rbst_div #(.CoordBits(CoordBits), .SideBits(3)) u_lo (
    .clk_i, .en_i, .a_i(lo_i), .o_i, .d_i, .side_i(side_in), .t_o(ta), .side_o(side_lo)
  );
  rbst_div #(.CoordBits(CoordBits), .SideBits(3)) u_hi (
    .clk_i, .en_i, .a_i(hi_i), .o_i, .d_i, .side_i(side_in), .t_o(tb), .side_o(side_hi)
  );

  // Order the pair.
  assign t0_o   = (ta > tb) ? tb : ta;
  assign t1_o   = (ta > tb) ? ta : tb;
  assign par_o  = side_lo[2];
  assign miss_o = side_lo[1];
  assign in_o   = side_hi[0];

endmodule

>>> hdl/ray_box_slab_test.sv
// Ray/box slab test: one ray and one box per item, signed fixed-point coordinates.
// Use: present all twelve coordinates with in_valid_i; one hit bit per item returns
// on out_valid_o/hit_o in the same order.
// Path from acceptance to result: divider entry register, divider steps, ordered-pair
// register and hit register; one bit-per-stage divider per slab bound on each axis.
// Throughput: one item per cycle while the receiver takes results.
// Stall: when out_ready_i is low with a result waiting, the whole pipeline holds and
// in_ready_o drops only if the output register is full; nothing is lost or repeated.
// Reset: rst_ni clears all valid bits; payload registers are not cleared.
// Depends on rbst_pkg, rbst_axis, rbst_div.
module ray_box_slab_test #(
  parameter int unsigned COORD_BITS = rbst_pkg::CoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] origin_z_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_z_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o
);
  localparam int unsigned DivStages = COORD_BITS + 1 + rbst_pkg::FracBits + 1;
  localparam int unsigned Depth     = DivStages + 2;
  localparam int unsigned NumAxes   = rbst_pkg::NumAxes;

  logic             en;
  logic [Depth-1:0] vld_q;

  // Advance when the last stage is free or drains.
  assign en         = ~vld_q[Depth-1] | out_ready_i;
  assign in_ready_o = en;

  logic signed [COORD_BITS-1:0] o  [NumAxes];
  logic signed [COORD_BITS-1:0] d  [NumAxes];
  logic signed [COORD_BITS-1:0] lo [NumAxes];
  logic signed [COORD_BITS-1:0] hi [NumAxes];
  assign o  = '{origin_x_i, origin_y_i, origin_z_i};
  assign d  = '{dir_x_i, dir_y_i, dir_z_i};
  assign lo = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi = '{box_max_x_i, box_max_y_i, box_max_z_i};

  logic signed [COORD_BITS-1:0] t0 [NumAxes];
  logic signed [COORD_BITS-1:0] t1 [NumAxes];
  logic [NumAxes-1:0] par, miss, ins;

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    rbst_axis #(.CoordBits(COORD_BITS)) u_axis (
      .clk_i, .en_i(en), .o_i(o[a]), .d_i(d[a]), .lo_i(lo[a]), .hi_i(hi[a]),
      .t0_o(t0[a]), .t1_o(t1[a]), .par_o(par[a]), .miss_o(miss[a]), .in_o(ins[a])
    );
  end

  // Register ordered pairs before narrowing.
  logic signed [COORD_BITS-1:0] t0_q [NumAxes];
  logic signed [COORD_BITS-1:0] t1_q [NumAxes];
  logic [NumAxes-1:0] par_q, ins_q;
  logic               miss_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q   <= t0;
      t1_q   <= t1;
      par_q  <= par;
      ins_q  <= ins;
      miss_q <= |miss;
    end
  end

  // Narrow near/far across non-parallel axes and decide.
  logic signed [COORD_BITS-1:0] tn, tf;
  logic ns, fs, ordered, tneg, hit_d, hit_q;
  always_comb begin
    tn = '0;
    tf = '0;
    ns = 1'b0;
    fs = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      if (!par_q[a]) begin
        if (!ns || t0_q[a] > tn) tn = t0_q[a];
        if (!fs || t1_q[a] < tf) tf = t1_q[a];
        ns = 1'b1;
        fs = 1'b1;
      end
    end
    ordered = !ns || (tn < tf);
    if (ns && tn > 0) tneg = 1'b0;
    else if (!fs)     tneg = 1'b0;
    else              tneg = tf < 0;
    hit_d = !miss_q && ordered && !(tneg && !(&ins_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) hit_q <= hit_d;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign hit_o       = hit_q;

  // Result waiting under stall stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o))
    else $error("held result changed");
  // Input side must be open whenever the output is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline blocked while empty");
  // Pipeline holds item count during stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

endmodule
